// ===== hw/rtl/med3_pkg.sv =====
package med3_pkg;
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned COL_W = 10;
  localparam int unsigned ROW_W = 16;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [15:0] HEIGHT_RST = 16'd480;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    pix_t             value;
    logic             last_of_run;
    logic             frame_done;
  } res_t;

  // compare-exchange helpers for the median network
  function automatic pix_t pmin(input pix_t a, input pix_t b);
    pmin = (a < b) ? a : b;
  endfunction
  function automatic pix_t pmax(input pix_t a, input pix_t b);
    pmax = (a < b) ? b : a;
  endfunction
endpackage

// ===== hw/rtl/med3_if.sv =====
interface med3_in_if;
  logic valid;
  logic ready;
  med3_pkg::pix_t pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface med3_out_if;
  logic valid;
  logic ready;
  med3_pkg::res_t res;
  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

// ===== hw/rtl/median_3x3_filter.sv =====
// channel | dir | handshake     | word
// in_ch   | in  | valid/ready   | pixel[7:0]
// out_ch  | out | valid/ready   | column, row, value, last_of_run, frame_done
// cfg     | in  | cfg_we        | cfg_idx selects width/height, cfg_data
// One pixel per cycle. Stage 1 reads the line RAMs (registered read), stage 2
// shifts the window and forms the median, stage 3 turns it into a run of up to
// 9 words. Runs wait in an 8-deep queue and expand one word per cycle into the
// output register while out_ch is not stalled (register empty or ready high).
// in_ch.ready drops while queued plus in-flight runs could fill the queue.
// Synchronous active-low reset; no clearing pass. Config write restarts frame.
module median_3x3_filter #(
  parameter int unsigned MAX_WIDTH = med3_pkg::MAX_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  med3_in_if.sink    in_ch,
  med3_out_if.source out_ch,
  input  logic                               cfg_we,
  input  logic [med3_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [med3_pkg::CFG_W-1:0]         cfg_data
);
  import med3_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RQD = 8;
  localparam int unsigned RQA = $clog2(RQD);

  typedef struct packed {
    pix_t             value;
    logic [COL_W-1:0] x0;
    logic [ROW_W-1:0] y0;
    logic [1:0]       nr;
    logic [1:0]       nc;
    logic             lastf;
  } run_t;

  // configuration
  logic [10:0] width_r;
  logic [15:0] height_r;
  logic [10:0] ew;
  logic [15:0] eh;
  always_comb begin
    ew = width_r;
    if (ew < 11'd3) ew = 11'd3;
    if ({21'd0, ew} > MAX_WIDTH) ew = 11'(MAX_WIDTH);
    eh = (height_r < 16'd3) ? 16'd3 : height_r;
  end

  // input acceptance and position
  logic [RQA:0] rq_cnt_r;
  logic [2:0]  inflt;
  logic s1_v_r, s2_v_r, s3_v_r;
  logic take;
  assign inflt = 3'(s1_v_r) + 3'(s2_v_r) + 3'(s3_v_r);
  // room for every run still in the pipe plus this one
  assign in_ch.ready = ({1'b0, rq_cnt_r} + {2'b00, inflt}) < 5'(RQD);
  assign take = in_ch.valid && in_ch.ready;

  logic [10:0] col_r;
  logic [15:0] row_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RST; height_r <= HEIGHT_RST;
      col_r <= '0; row_r <= '0;
    end else if (cfg_we && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT)) begin
      if (cfg_idx == REG_WIDTH) width_r <= cfg_data[10:0];
      else height_r <= cfg_data;
      col_r <= '0; row_r <= '0;
    end else if (take) begin
      if (col_r + 11'd1 >= ew) begin
        col_r <= '0;
        row_r <= (row_r + 16'd1 >= eh) ? 16'd0 : row_r + 16'd1;
      end else begin
        col_r <= col_r + 11'd1;
      end
    end
  end

  // stage 1: line RAM read, write back shifted column
  logic [PIX_W-1:0] l2_mem [MAX_WIDTH];
  logic [PIX_W-1:0] l1_mem [MAX_WIDTH];
  logic [PIX_W-1:0] l2_rd_r, l1_rd_r, p1_r;
  logic [10:0] c1_r;
  logic [15:0] r1_r;
  logic [AW-1:0] wa_r;
  logic wb_r;
  logic [PIX_W-1:0] wb2_r, wb1_r;
  always_ff @(posedge clk) begin
    if (take) begin
      l2_rd_r <= l2_mem[AW'(col_r)];
      l1_rd_r <= l1_mem[AW'(col_r)];
    end
    if (wb_r) begin
      l2_mem[wa_r] <= wb2_r;
      l1_mem[wa_r] <= wb1_r;
    end
  end
  logic [PIX_W-1:0] t2, t1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; wb_r <= 1'b0;
    end else begin
      s1_v_r <= take;
      wb_r   <= s1_v_r;
    end
    if (take) begin
      p1_r <= in_ch.pixel; c1_r <= col_r; r1_r <= row_r;
    end
    if (s1_v_r) begin
      wa_r <= AW'(c1_r); wb2_r <= t1; wb1_r <= p1_r;
    end
  end
  // W>=3, so a column is written back before the same column is read again
  assign t2 = l2_rd_r;
  assign t1 = l1_rd_r;

  // stage 2: window shift
  pix_t win_r [3][3];
  logic [10:0] c2_r;
  logic [15:0] r2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win_r[i][j] <= '0;
    end else begin
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        win_r[0] <= win_r[1]; win_r[1] <= win_r[2];
        win_r[2][0] <= t2; win_r[2][1] <= t1; win_r[2][2] <= p1_r;
      end
    end
    if (s1_v_r) begin
      c2_r <= c1_r; r2_r <= r1_r;
    end
  end

  // median network (columns sorted, then min/med/max combine)
  pix_t s[5];
  pix_t lo[3], md[3], hi[3];
  pix_t med_c;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pix_t a, b, c, x, y;
      a = win_r[k][0]; b = win_r[k][1]; c = win_r[k][2];
      x = pmin(a, b); y = pmax(a, b);
      lo[k] = pmin(x, c);
      hi[k] = pmax(y, c);
      md[k] = pmax(x, pmin(y, c));
    end
    s[0] = pmax(pmax(lo[0], lo[1]), lo[2]);
    s[1] = pmin(pmin(hi[0], hi[1]), hi[2]);
    s[2] = pmax(pmin(md[0], md[1]), pmin(pmax(md[0], md[1]), md[2]));
    s[3] = pmin(s[0], s[1]); s[4] = pmax(s[0], s[1]);
    med_c = pmax(s[3], pmin(s[4], s[2]));
  end

  pix_t med_r;
  logic [10:0] c3_r;
  logic [15:0] r3_r;
  logic emit;
  assign emit = s2_v_r && c2_r >= 11'd2 && r2_r >= 16'd2;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else        s3_v_r <= emit;
    if (emit) begin
      med_r <= med_c; c3_r <= c2_r; r3_r <= r2_r;
    end
  end

  // stage 3: run descriptor, up to 3 rows x 3 cols
  logic [10:0] xs;
  logic [15:0] ys;
  logic [1:0] nr, nc;
  logic top_x, top_y;
  run_t run_w;
  always_comb begin
    xs = c3_r - 11'd1; ys = r3_r - 16'd1;
    top_x = (xs == 11'd1); top_y = (ys == 16'd1);
    nc = 2'd1 + 2'(top_x) + 2'(xs == ew - 11'd2);
    nr = 2'd1 + 2'(top_y) + 2'(ys == eh - 16'd2);
    run_w.value = med_r;
    run_w.x0    = COL_W'(xs - 11'(top_x));
    run_w.y0    = ys - 16'(top_y);
    run_w.nr    = nr;
    run_w.nc    = nc;
    run_w.lastf = (c3_r == ew - 11'd1) && (r3_r == eh - 16'd1);
  end

  // run queue and expander into the output register
  run_t rq_mem [RQD];
  logic [RQA-1:0] rq_wp_r, rq_rp_r;
  logic rq_push, rq_pop;
  run_t ex_r;
  logic ex_busy_r;
  logic [1:0] ai_r, bi_r;
  logic ov_r;
  res_t ow_r;
  logic adv, lastr, ex_done;
  res_t push_w;
  assign rq_push = s3_v_r;
  assign adv     = ex_busy_r && (!ov_r || out_ch.ready);
  assign lastr   = (ai_r == ex_r.nr - 2'd1) && (bi_r == ex_r.nc - 2'd1);
  assign ex_done = adv && lastr;
  assign rq_pop  = (rq_cnt_r != '0) && (!ex_busy_r || ex_done);
  always_comb begin
    push_w.column      = ex_r.x0 + COL_W'(bi_r);
    push_w.row         = ex_r.y0 + ROW_W'(ai_r);
    push_w.value       = ex_r.value;
    push_w.last_of_run = lastr;
    push_w.frame_done  = lastr && ex_r.lastf;
  end
  always_ff @(posedge clk) begin
    if (rq_push) rq_mem[rq_wp_r] <= run_w;
    if (rq_pop)  ex_r <= rq_mem[rq_rp_r];
    if (adv)     ow_r <= push_w;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wp_r <= '0; rq_rp_r <= '0; rq_cnt_r <= '0;
      ex_busy_r <= 1'b0; ai_r <= '0; bi_r <= '0; ov_r <= 1'b0;
    end else begin
      if (rq_push) rq_wp_r <= rq_wp_r + RQA'(1);
      if (rq_pop)  rq_rp_r <= rq_rp_r + RQA'(1);
      rq_cnt_r <= rq_cnt_r + (RQA+1)'(rq_push) - (RQA+1)'(rq_pop);
      if (rq_pop) begin
        ex_busy_r <= 1'b1; ai_r <= '0; bi_r <= '0;
      end else if (ex_done) begin
        ex_busy_r <= 1'b0;
      end else if (adv) begin
        if (bi_r == ex_r.nc - 2'd1) begin bi_r <= '0; ai_r <= ai_r + 2'd1; end
        else bi_r <= bi_r + 2'd1;
      end
      if (adv) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end
  assign out_ch.valid = ov_r;
  assign out_ch.res   = ow_r;
endmodule
